FILE: hw/rtl/mbrrb_pkg.sv
`timescale 1ns / 1ps
package mbrrb_pkg;
  localparam int NUM_BANKS = 8;
  localparam int MEMGO_BIT = 19;
  localparam int BIDX_W = 3;

  typedef enum logic [4:0] {
    SEL_SUBBUS = 5'd0, SEL_PM = 5'd1, SEL_START0 = 5'd2, SEL_START1 = 5'd3,
    SEL_EXTS0 = 5'd4, SEL_EXTS1 = 5'd5, SEL_END0 = 5'd6, SEL_END1 = 5'd7,
    SEL_EXTE0 = 5'd8, SEL_EXTE1 = 5'd9, SEL_BANKEN = 5'd10, SEL_PICR0 = 5'd11,
    SEL_PICR1 = 5'd12, SEL_MCCR1 = 5'd13, SEL_MCCR2 = 5'd14, SEL_MCCR3 = 5'd15,
    SEL_MCCR4 = 5'd16
  } sel_t;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_REGION = 1'b1;

  typedef struct packed {
    logic        command;
    logic [4:0]  register_select;
    logic [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] read_data;
    logic [29:0] region_start;
    logic [30:0] region_bytes;
    logic        last_region;
    logic        overlap_seen;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  enable;
    logic [31:0] start_lo0, start_lo1, start_ext0, start_ext1;
    logic [31:0] end_lo0, end_lo1, end_ext0, end_ext1;
  } bank_cfg_t;
endpackage

FILE: hw/rtl/memory_bank_register_region_builder.sv
`timescale 1ns / 1ps
// channel | dir | handshake          | payload
// in_     | in  | in_valid/in_ready  | mbrrb_pkg::req_t
// out_    | out | out_valid/out_ready| mbrrb_pkg::rsp_t
// A read is captured into the output register; other writes update the register file.
// A memory-go write runs up to 9 passes (a scan of all 8 banks in the
// shared compare unit, then merge; one pass per usable bank plus a closing
// pass) and, if a region is open, an emit step; output stalls can hold a merge or the emit.
// in_ready is low during a build and while a result waits unaccepted.
// Reset is synchronous; the register file clears to zero.
module memory_bank_register_region_builder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mbrrb_pkg::req_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mbrrb_pkg::rsp_t   out_data
);
  import mbrrb_pkg::*;

  logic [15:0] pm_low_r;
  logic [7:0] pm_mid_r, odc_r, en_r;
  logic [31:0] sl_r [2];
  logic [31:0] se_r [2];
  logic [31:0] el_r [2];
  logic [31:0] ee_r [2];
  logic [31:0] picr_r [2];
  logic [31:0] mccr_r [4];
  logic rd_valid_r;
  logic [31:0] rd_data_r;

  logic bld_busy, bld_valid, bld_start, acc;
  rsp_t bld_rsp;
  bank_cfg_t cfg;
  logic [31:0] rval;
  logic [31:0] go_mask;

  assign go_mask = 32'd1 << MEMGO_BIT;
  assign in_ready = !bld_busy && !rd_valid_r;
  assign acc = in_valid && in_ready;
  assign bld_start = acc && in_data.command == CMD_WRITE && in_data.register_select == SEL_MCCR1
    && ((in_data.write_value & ~mccr_r[0] & go_mask) != 32'd0);

  assign cfg = '{enable: en_r, start_lo0: sl_r[0], start_lo1: sl_r[1],
                 start_ext0: se_r[0], start_ext1: se_r[1], end_lo0: el_r[0],
                 end_lo1: el_r[1], end_ext0: ee_r[0], end_ext1: ee_r[1]};

  always_comb begin
    case (in_data.register_select)
      SEL_PM: rval = {odc_r, pm_mid_r, pm_low_r};
      SEL_START0, SEL_START1: rval = sl_r[in_data.register_select[0]];
      SEL_EXTS0, SEL_EXTS1: rval = se_r[in_data.register_select[0]];
      SEL_END0, SEL_END1: rval = el_r[in_data.register_select[0]];
      SEL_EXTE0, SEL_EXTE1: rval = ee_r[in_data.register_select[0]];
      SEL_BANKEN: rval = {24'd0, en_r};
      SEL_PICR0: rval = picr_r[0];
      SEL_PICR1: rval = picr_r[1];
      SEL_MCCR1: rval = mccr_r[0];
      SEL_MCCR2: rval = mccr_r[1];
      SEL_MCCR3: rval = mccr_r[2];
      SEL_MCCR4: rval = mccr_r[3];
      default: rval = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_low_r <= '0; pm_mid_r <= '0; odc_r <= '0; en_r <= '0;
      sl_r <= '{default: '0}; se_r <= '{default: '0};
      el_r <= '{default: '0}; ee_r <= '{default: '0};
      picr_r <= '{default: '0}; mccr_r <= '{default: '0};
      rd_valid_r <= 1'b0;
    end else begin
      if (rd_valid_r && out_ready) rd_valid_r <= 1'b0;
      if (acc && in_data.command == CMD_READ) begin
        rd_valid_r <= 1'b1;
        rd_data_r <= rval;
      end
      if (acc && in_data.command == CMD_WRITE) begin
        case (in_data.register_select)
          SEL_PM: begin
            pm_low_r <= in_data.write_value[15:0];
            pm_mid_r <= in_data.write_value[23:16];
            odc_r <= in_data.write_value[31:24];
          end
          SEL_START0, SEL_START1: sl_r[in_data.register_select[0]] <= in_data.write_value;
          SEL_EXTS0, SEL_EXTS1: se_r[in_data.register_select[0]] <= in_data.write_value;
          SEL_END0, SEL_END1: el_r[in_data.register_select[0]] <= in_data.write_value;
          SEL_EXTE0, SEL_EXTE1: ee_r[in_data.register_select[0]] <= in_data.write_value;
          SEL_BANKEN: en_r <= in_data.write_value[7:0];
          SEL_PICR0: picr_r[0] <= in_data.write_value;
          SEL_PICR1: picr_r[1] <= in_data.write_value;
          SEL_MCCR1: mccr_r[0] <= in_data.write_value;
          SEL_MCCR2: mccr_r[1] <= in_data.write_value;
          SEL_MCCR3: mccr_r[2] <= in_data.write_value;
          SEL_MCCR4: mccr_r[3] <= in_data.write_value;
          default: ;
        endcase
      end
    end
  end

  mbrrb_builder u_bld (
    .clk(clk), .rst_n(rst_n), .start(bld_start), .cfg(cfg), .busy(bld_busy),
    .rsp_valid(bld_valid), .rsp_ready(out_ready), .rsp(bld_rsp)
  );

  assign out_valid = rd_valid_r || bld_valid;
  always_comb begin
    if (rd_valid_r) begin
      out_data = '0;
      out_data.result_kind = KIND_READ;
      out_data.read_data = rd_data_r;
    end else begin
      out_data = bld_rsp;
    end
  end

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_valid_r && bld_valid)) else $error("two sources");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bld_busy |-> !in_ready) else $error("accept during build");
  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r && !out_ready |=> rd_valid_r && $stable(rd_data_r)) else $error("read lost");
endmodule

FILE: hw/rtl/mbrrb_builder.sv
`timescale 1ns / 1ps
module mbrrb_builder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  mbrrb_pkg::bank_cfg_t cfg,
  output logic                 busy,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output mbrrb_pkg::rsp_t      rsp
);
  import mbrrb_pkg::*;

  // Repeated min search: each pass scans all banks (one per cycle) for the
  // smallest unused start, then merges it into the open region or opens a new one.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_SCAN = 4'b0010, ST_MERGE = 4'b0100, ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [NUM_BANKS-1:0] used_r;
  logic [BIDX_W-1:0] idx_r;
  logic found_r;
  logic [BIDX_W-1:0] best_r;
  logic [29:0] best_st_r, best_en_r;
  logic have_r, ovl_r;
  logic [29:0] rs_r, re_r;
  logic pend_r;
  logic [29:0] pst_r, pen_r;
  logic plast_r, povl_r;

  logic [1:0] ext_s, ext_e;
  logic [7:0] lo_s, lo_e;
  logic [29:0] cur_st, cur_en;
  logic cur_ok;
  logic [2:0] lane;

  assign lane = idx_r;
  always_comb begin
    if (!lane[2]) begin
      ext_s = cfg.start_ext0[{lane[1:0], 3'b000} +: 2];
      ext_e = cfg.end_ext0[{lane[1:0], 3'b000} +: 2];
      lo_s  = cfg.start_lo0[{lane[1:0], 3'b000} +: 8];
      lo_e  = cfg.end_lo0[{lane[1:0], 3'b000} +: 8];
    end else begin
      ext_s = cfg.start_ext1[{lane[1:0], 3'b000} +: 2];
      ext_e = cfg.end_ext1[{lane[1:0], 3'b000} +: 2];
      lo_s  = cfg.start_lo1[{lane[1:0], 3'b000} +: 8];
      lo_e  = cfg.end_lo1[{lane[1:0], 3'b000} +: 8];
    end
    cur_st = {ext_s, lo_s, 20'h00000};
    cur_en = {ext_e, lo_e, 20'hFFFFF};
    cur_ok = cfg.enable[idx_r] && !used_r[idx_r] && !(cur_en < cur_st);
  end

  logic last_idx;
  assign last_idx = (idx_r == BIDX_W'(NUM_BANKS - 1));
  logic [30:0] re_p1;
  assign re_p1 = {1'b0, re_r} + 31'd1;

  logic merge_hit, can_load, load_pend;
  assign merge_hit = have_r && ({1'b0, best_st_r} <= re_p1);
  assign can_load = !pend_r || rsp_ready;
  assign load_pend = (state_r == ST_MERGE && found_r && !merge_hit && have_r && can_load)
                     || (state_r == ST_EMIT && can_load);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_SCAN;
      ST_SCAN:  if (last_idx) state_nxt = ST_MERGE;
      ST_MERGE: if (!found_r && have_r) state_nxt = ST_EMIT;
                else if (!found_r) state_nxt = ST_IDLE;
                else if (have_r && {1'b0, best_st_r} > re_p1 && pend_r && !rsp_ready)
                  state_nxt = ST_MERGE;
                else state_nxt = ST_SCAN;
      ST_EMIT:  if (!pend_r || rsp_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  logic take;
  assign take = pend_r && rsp_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r <= 1'b0;
      have_r <= 1'b0;
      found_r <= 1'b0;
      used_r <= '0;
      idx_r <= '0;
      ovl_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_pend) pend_r <= 1'b1;
      else if (take) pend_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          used_r <= '0;
          have_r <= 1'b0;
          ovl_r <= 1'b0;
          idx_r <= '0;
          found_r <= 1'b0;
        end
        ST_SCAN: begin
          if (cur_ok && (!found_r || cur_st < best_st_r)) begin
            found_r <= 1'b1;
            best_r <= idx_r;
            best_st_r <= cur_st;
            best_en_r <= cur_en;
          end
          idx_r <= last_idx ? '0 : idx_r + 1'b1;
        end
        ST_MERGE: begin
          if (found_r) begin
            if (merge_hit) begin
              if (best_st_r <= re_r) ovl_r <= 1'b1;
              if (best_en_r > re_r) re_r <= best_en_r;
              used_r[best_r] <= 1'b1;
              found_r <= 1'b0;
            end else if (!have_r || can_load) begin
              if (have_r) begin
                pst_r <= rs_r;
                pen_r <= re_r;
                plast_r <= 1'b0;
                povl_r <= 1'b0;
              end
              have_r <= 1'b1;
              rs_r <= best_st_r;
              re_r <= best_en_r;
              used_r[best_r] <= 1'b1;
              found_r <= 1'b0;
            end
          end
        end
        ST_EMIT: begin
          if (can_load) begin
            pst_r <= rs_r;
            pen_r <= re_r;
            plast_r <= 1'b1;
            povl_r <= ovl_r;
            have_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  logic [30:0] size;
  assign size = {1'b0, pen_r} - {1'b0, pst_r} + 31'd1;
  assign busy = (state_r != ST_IDLE) || pend_r;
  assign rsp_valid = pend_r;
  always_comb begin
    rsp = '0;
    rsp.result_kind = KIND_REGION;
    rsp.region_start = pst_r;
    rsp.region_bytes = size;
    rsp.last_region = plast_r;
    rsp.overlap_seen = povl_r;
  end

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_valid && !rsp.last_region |-> !rsp.overlap_seen) else $error("overlap off last");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> busy) else $error("busy low");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(pst_r)) else $error("region dropped");
endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mbrrb_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  memory_bank_register_region_builder u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  localparam logic [4:0] SEL_OTHER = 5'd17;
  localparam logic [4:0] SEL_TOP = 5'd31;
  localparam logic [31:0] GO = 32'h1 << MEMGO_BIT;

  // shadow register state
  logic [15:0] pm_low;
  logic [7:0]  pm_mid;
  logic [7:0]  drive_ctrl;
  logic [31:0] start_lo [2];
  logic [31:0] start_ext [2];
  logic [31:0] end_lo [2];
  logic [31:0] end_ext [2];
  logic [7:0]  bank_en;
  logic [31:0] picr [2];
  logic [31:0] mccr [4];

  rsp_t expected_q [$];
  int   n_err;
  int   n_reads;
  int   n_regions;
  int   n_builds;
  int   send_idle_pct;
  int   recv_idle_pct;

  typedef struct {
    logic        cmd;
    logic [4:0]  sel;
    logic [31:0] val;
    logic        has_exp;
    logic [31:0] exp_data;
  } row_t;

  function automatic logic [31:0] shadow_read(input logic [4:0] sel);
    case (sel)
      SEL_PM: return {drive_ctrl, pm_mid, pm_low};
      SEL_START0, SEL_START1: return start_lo[sel[0]];
      SEL_EXTS0, SEL_EXTS1: return start_ext[sel[0]];
      SEL_END0, SEL_END1: return end_lo[sel[0]];
      SEL_EXTE0, SEL_EXTE1: return end_ext[sel[0]];
      SEL_BANKEN: return {24'h0, bank_en};
      SEL_PICR0, SEL_PICR1: return picr[1'(sel - SEL_PICR0)];
      SEL_MCCR1, SEL_MCCR2, SEL_MCCR3, SEL_MCCR4: return mccr[2'(sel - SEL_MCCR1)];
      default: return 32'h0;
    endcase
  endfunction

  task automatic build_regions();
    logic [31:0] st [$];
    logic [31:0] en [$];
    logic [31:0] rs [$];
    logic [31:0] re [$];
    logic [31:0] bs;
    logic [31:0] be;
    logic        ovl;
    int          w;
    int          s;
    int          k;
    rsp_t        r;
    ovl = 1'b0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (!bank_en[b]) continue;
      w = b >> 2;
      s = (b & 3) * 8;
      bs = (((start_ext[w] >> s) & 32'h3) << 28) | (((start_lo[w] >> s) & 32'hFF) << 20);
      be = (((end_ext[w] >> s) & 32'h3) << 28) | (((end_lo[w] >> s) & 32'hFF) << 20)
           | 32'hFFFFF;
      if (be < bs) continue;
      k = st.size();
      while (k > 0 && st[k-1] > bs) k--;
      st.insert(k, bs);
      en.insert(k, be);
    end
    foreach (st[i]) begin
      if (rs.size() > 0 && st[i] <= re[$] + 1) begin
        if (st[i] <= re[$]) ovl = 1'b1;
        if (en[i] > re[$]) re[$] = en[i];
      end else begin
        rs.push_back(st[i]);
        re.push_back(en[i]);
      end
    end
    if (rs.size() > 0) n_builds++;
    foreach (rs[i]) begin
      r = '0;
      r.result_kind = KIND_REGION;
      r.region_start = rs[i][29:0];
      r.region_bytes = 31'(re[i] - rs[i] + 1);
      r.last_region = (i == rs.size() - 1);
      r.overlap_seen = r.last_region && ovl;
      expected_q.push_back(r);
    end
  endtask

  task automatic predict_request(input req_t q);
    rsp_t r;
    logic [31:0] v;
    v = q.write_value;
    if (q.command == CMD_READ) begin
      r = '0;
      r.result_kind = KIND_READ;
      r.read_data = shadow_read(q.register_select);
      expected_q.push_back(r);
      return;
    end
    case (q.register_select)
      SEL_PM: begin
        pm_low = v[15:0];
        pm_mid = v[23:16];
        drive_ctrl = v[31:24];
      end
      SEL_START0, SEL_START1: start_lo[q.register_select[0]] = v;
      SEL_EXTS0, SEL_EXTS1: start_ext[q.register_select[0]] = v;
      SEL_END0, SEL_END1: end_lo[q.register_select[0]] = v;
      SEL_EXTE0, SEL_EXTE1: end_ext[q.register_select[0]] = v;
      SEL_BANKEN: bank_en = v[7:0];
      SEL_PICR0, SEL_PICR1: picr[1'(q.register_select - SEL_PICR0)] = v;
      SEL_MCCR1: begin
        if (((v ^ mccr[0]) & GO) != 0 && (v & GO) != 0) build_regions();
        mccr[0] = v;
      end
      SEL_MCCR2, SEL_MCCR3, SEL_MCCR4: mccr[2'(q.register_select - SEL_MCCR1)] = v;
      default: ;
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("memory_bank_register_region_builder: mismatch");
    $finish;
  end

  task automatic send_request(input logic cmd, input logic [4:0] sel, input logic [31:0] val);
    req_t q;
    q.command = cmd;
    q.register_select = sel;
    q.write_value = val;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(q);
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = expected_q.pop_front();
        if (out_data.result_kind == KIND_READ) n_reads++;
        else n_regions++;
        if (out_data !== e) begin
          n_err++;
          if (n_err <= 10) $display("result mismatch: exp %p got %p", e, out_data);
        end
      end
    end
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [31:0] bank_bytes();
    return {$urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(15)),
            $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(15)),
            $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(15)),
            $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(15))};
  endfunction

  row_t rows [$];

  initial begin
    int n;
    logic [4:0] sel;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    n_err = 0;
    n_reads = 0;
    n_regions = 0;
    n_builds = 0;
    pm_low = '0;
    pm_mid = '0;
    drive_ctrl = '0;
    bank_en = '0;
    for (int i = 0; i < 2; i++) begin
      start_lo[i] = '0;
      start_ext[i] = '0;
      end_lo[i] = '0;
      end_ext[i] = '0;
      picr[i] = '0;
    end
    for (int i = 0; i < 4; i++) mccr[i] = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows = '{
      '{CMD_READ,  SEL_PM,     32'h0,          1'b1, 32'h0},
      '{CMD_READ,  SEL_SUBBUS, 32'h0,          1'b1, 32'h0},
      '{CMD_WRITE, SEL_SUBBUS, 32'hFFFFFFFF,   1'b0, 32'h0},
      '{CMD_READ,  SEL_SUBBUS, 32'h0,          1'b1, 32'h0},
      '{CMD_WRITE, SEL_OTHER,  32'hFFFFFFFF,   1'b0, 32'h0},
      '{CMD_READ,  SEL_TOP,    32'hFFFFFFFF,   1'b1, 32'h0},
      '{CMD_WRITE, SEL_PM,     32'hFFFFFFFF,   1'b0, 32'h0},
      '{CMD_READ,  SEL_PM,     32'h0,          1'b1, 32'hFFFFFFFF},
      '{CMD_WRITE, SEL_BANKEN, 32'hFFFFFFFF,   1'b0, 32'h0},
      '{CMD_READ,  SEL_BANKEN, 32'h0,          1'b1, 32'h000000FF},
      '{CMD_WRITE, SEL_START0, 32'h03020100,   1'b0, 32'h0},
      '{CMD_WRITE, SEL_START1, 32'hFF100804,   1'b0, 32'h0},
      '{CMD_WRITE, SEL_EXTS1,  32'h03000000,   1'b0, 32'h0},
      '{CMD_WRITE, SEL_END0,   32'h03020100,   1'b0, 32'h0},
      '{CMD_WRITE, SEL_END1,   32'h00200A06,   1'b0, 32'h0},
      '{CMD_WRITE, SEL_EXTE1,  32'h03000000,   1'b0, 32'h0},
      '{CMD_WRITE, SEL_MCCR1,  32'hFFFFFFFF,   1'b0, 32'h0},
      '{CMD_WRITE, SEL_MCCR1,  32'hFFFFFFFF,   1'b0, 32'h0},
      '{CMD_WRITE, SEL_MCCR1,  32'h0,          1'b0, 32'h0},
      '{CMD_WRITE, SEL_BANKEN, 32'h0,          1'b0, 32'h0},
      '{CMD_WRITE, SEL_MCCR1,  GO,             1'b0, 32'h0},
      '{CMD_WRITE, SEL_PICR1,  32'hA5A5A5A5,   1'b0, 32'h0},
      '{CMD_READ,  SEL_PICR1,  32'h0,          1'b1, 32'hA5A5A5A5},
      '{CMD_WRITE, SEL_MCCR4,  32'h5A5A5A5A,   1'b0, 32'h0},
      '{CMD_READ,  SEL_MCCR4,  32'h0,          1'b1, 32'h5A5A5A5A}
    };
    foreach (rows[i]) begin
      if (rows[i].has_exp && rows[i].exp_data != shadow_read(rows[i].sel)) begin
        n_err++;
        $display("table row %0d disagrees with shadow state", i);
      end
      send_request(rows[i].cmd, rows[i].sel, rows[i].val);
    end

    n = 0;
    while (n < 355) begin
      if (n >= 240) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (n >= 120) begin
        send_idle_pct = 88;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 10;
        recv_idle_pct = 88;
      end
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          // program banks, then kick a build
          send_request(CMD_WRITE, 5'($urandom_range(SEL_START0, SEL_EXTE1)),
                       $urandom_range(9) < 2 ? $urandom : bank_bytes());
          send_request(CMD_WRITE, SEL_BANKEN, $urandom);
          send_request(CMD_WRITE, SEL_MCCR1, $urandom & ~GO);
          send_request(CMD_WRITE, SEL_MCCR1, $urandom | GO);
          n += 4;
        end
        4, 5, 6: begin
          send_request(CMD_READ, 5'($urandom), $urandom);
          n++;
        end
        default: begin
          sel = $urandom_range(9) == 0 ? 5'($urandom) : 5'($urandom_range(SEL_PM, SEL_MCCR4));
          send_request(CMD_WRITE, sel, $urandom);
          n++;
        end
      endcase
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d reads and %0d regions from %0d builds", n_reads, n_regions,
             n_builds);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("memory_bank_register_region_builder: match");
    end else begin
      $display("memory_bank_register_region_builder: mismatch");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/mbrrb_pkg.sv
hw/rtl/mbrrb_builder.sv
hw/rtl/memory_bank_register_region_builder.sv
dv/tb_top.sv
